@@ rtl/psch_pkg.sv @@
`timescale 1ns / 1ps
package psch_pkg;

    localparam int THREAD_SLOTS_DEF = 16;
    localparam logic [31:0] NEVER_MS = 32'hFFFF_FFFF;
    localparam logic [31:0] TIMEOUT_VALUE = 32'hFFFF_FFFC;
    localparam logic [7:0] BOOT_PRIORITY = 8'd14;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        RS_READY   = 2'd0,
        RS_RUN     = 2'd1,
        RS_SLEEP   = 2'd2,
        RS_BLOCKED = 2'd3
    } run_state_t;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_PARK  = 2'd1,
        OP_WAKE  = 2'd2,
        OP_SCHED = 2'd3
    } op_t;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_NO_SLOT = 2'd1;
    localparam logic [1:0] ST_IDLE = 2'd2;

    typedef struct packed {
        op_t         op;
        logic [3:0]  slot;
        logic [7:0]  prio;
        logic        blocked;
        logic [31:0] deadline;
        logic [31:0] value;
    } item_t;

endpackage

@@ rtl/psch_front.sv @@
`timescale 1ns / 1ps
module psch_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           func,
    input  logic [3:0]           slot,
    input  logic [7:0]           priority_req,
    input  logic                 wait_blocked,
    input  logic [31:0]          deadline,
    input  logic [31:0]          value,
    output logic                 q_valid,
    output psch_pkg::item_t      q_item,
    input  logic                 q_pop
);
    import psch_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    item_t           mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW:0]     count_reg;
    item_t           item_in;
    logic            push;
    logic            pop;

    always_comb
    begin
        item_in.op       = op_t'(func);
        item_in.slot     = slot;
        item_in.prio     = priority_req;
        item_in.blocked  = wait_blocked;
        item_in.deadline = deadline;
        item_in.value    = value;
    end

    assign in_ready = (count_reg != (PW+1)'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/psch_core.sv @@
`timescale 1ns / 1ps
module psch_core #(
    parameter int THREAD_SLOTS = psch_pkg::THREAD_SLOTS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  psch_pkg::item_t      q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [3:0]           chosen_slot,
    output logic [31:0]          chosen_id,
    output logic [31:0]          chosen_value,
    output logic                 switched,
    output logic [31:0]          clock_now
);
    import psch_pkg::*;

    localparam int IW = $clog2(THREAD_SLOTS);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_ALLOC = 8'b0000_0010,
        S_PARK  = 8'b0000_0100,
        S_WKS   = 8'b0000_1000,
        S_SAVE  = 8'b0001_0000,
        S_PICK  = 8'b0010_0000,
        S_EARLY = 8'b0100_0000,
        S_WAKE  = 8'b1000_0000
    } fsm_t;

    fsm_t            state_reg;
    logic            fin_reg;
    logic            idle_reg;
    item_t           item_reg;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   cur_reg;
    logic            bv_reg;
    logic [IW-1:0]   bi_reg;
    logic [7:0]      bp_reg;
    logic [31:0]     ear_reg;
    logic            jumped_reg;
    logic [31:0]     next_id_reg;
    logic [31:0]     clock_reg;

    logic            used_reg  [THREAD_SLOTS];
    run_state_t      rs_reg    [THREAD_SLOTS];
    logic [7:0]      prio_reg  [THREAD_SLOTS];
    logic [31:0]     wake_reg  [THREAD_SLOTS];
    logic [31:0]     val_reg   [THREAD_SLOTS];
    logic [31:0]     id_reg    [THREAD_SLOTS];

    logic            rd_used;
    run_state_t      rd_rs;
    logic [7:0]      rd_prio;
    logic [31:0]     rd_wake;
    logic            rd_waiting;
    logic            last;
    logic            pick_hit;
    logic            early_hit;
    logic            wake_hit;
    logic            slot_ok;
    logic            start;

    assign rd_used    = used_reg[idx_reg];
    assign rd_rs      = rs_reg[idx_reg];
    assign rd_prio    = prio_reg[idx_reg];
    assign rd_wake    = wake_reg[idx_reg];
    assign rd_waiting = (rd_rs == RS_SLEEP) || (rd_rs == RS_BLOCKED);
    assign last       = (idx_reg == IW'(THREAD_SLOTS-1));
    assign pick_hit   = rd_used && (rd_rs == RS_READY) && (!bv_reg || rd_prio > bp_reg);
    assign early_hit  = rd_used && rd_waiting && (rd_wake != NEVER_MS) && (rd_wake < ear_reg);
    assign wake_hit   = rd_used && rd_waiting && (rd_wake != NEVER_MS) && (rd_wake <= clock_reg);
    assign slot_ok    = (32'(q_item.slot) < 32'(THREAD_SLOTS));
    assign start      = (state_reg == S_IDLE) && !fin_reg && q_valid && !out_valid;
    assign q_pop      = start;
    assign clock_now  = clock_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fin_reg      <= 1'b0;
            idle_reg     <= 1'b0;
            item_reg     <= '0;
            idx_reg      <= '0;
            cur_reg      <= '0;
            bv_reg       <= 1'b0;
            bi_reg       <= '0;
            bp_reg       <= '0;
            ear_reg      <= NEVER_MS;
            jumped_reg   <= 1'b0;
            next_id_reg  <= 32'd1;
            clock_reg    <= '0;
            out_valid    <= 1'b0;
            status       <= ST_DONE;
            chosen_slot  <= '0;
            chosen_id    <= '0;
            chosen_value <= '0;
            switched     <= 1'b0;
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                used_reg[i] <= (i == 0);
                rs_reg[i]   <= (i == 0) ? RS_RUN : RS_READY;
                prio_reg[i] <= (i == 0) ? BOOT_PRIORITY : 8'd0;
                wake_reg[i] <= NEVER_MS;
                val_reg[i]  <= '0;
                id_reg[i]   <= '0;
            end
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            if (fin_reg)
            begin
                fin_reg      <= 1'b0;
                out_valid    <= 1'b1;
                chosen_slot  <= 4'(idx_reg);
                chosen_id    <= id_reg[idx_reg];
                chosen_value <= val_reg[idx_reg];
                if (idle_reg)
                begin
                    status   <= ST_IDLE;
                    switched <= 1'b0;
                end
                else
                begin
                    status          <= ST_DONE;
                    switched        <= 1'b1;
                    rs_reg[idx_reg] <= RS_RUN;
                    cur_reg         <= idx_reg;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        item_reg <= q_item;
                        case (q_item.op)
                            OP_ALLOC:
                            begin
                                idx_reg   <= '0;
                                state_reg <= S_ALLOC;
                            end
                            OP_PARK:
                            begin
                                idx_reg   <= cur_reg;
                                state_reg <= S_PARK;
                            end
                            OP_WAKE:
                            begin
                                if (slot_ok)
                                begin
                                    idx_reg   <= IW'(q_item.slot);
                                    state_reg <= S_WKS;
                                end
                                else
                                begin
                                    out_valid    <= 1'b1;
                                    status       <= ST_DONE;
                                    chosen_slot  <= '0;
                                    chosen_id    <= '0;
                                    chosen_value <= '0;
                                    switched     <= 1'b0;
                                end
                            end
                            default:
                            begin
                                idx_reg    <= cur_reg;
                                jumped_reg <= 1'b0;
                                state_reg  <= S_SAVE;
                            end
                        endcase
                    end
                end
                S_ALLOC:
                begin
                    if (!rd_used)
                    begin
                        used_reg[idx_reg] <= 1'b1;
                        rs_reg[idx_reg]   <= RS_READY;
                        prio_reg[idx_reg] <= item_reg.prio;
                        wake_reg[idx_reg] <= NEVER_MS;
                        val_reg[idx_reg]  <= '0;
                        id_reg[idx_reg]   <= next_id_reg;
                        next_id_reg       <= next_id_reg + 32'd1;
                        out_valid         <= 1'b1;
                        status            <= ST_DONE;
                        chosen_slot       <= 4'(idx_reg);
                        chosen_id         <= next_id_reg;
                        chosen_value      <= '0;
                        switched          <= 1'b0;
                        state_reg         <= S_IDLE;
                    end
                    else if (last)
                    begin
                        out_valid    <= 1'b1;
                        status       <= ST_NO_SLOT;
                        chosen_slot  <= '0;
                        chosen_id    <= '0;
                        chosen_value <= '0;
                        switched     <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_PARK, S_WKS:
                begin
                    if (state_reg == S_PARK)
                    begin
                        rs_reg[idx_reg]   <= item_reg.blocked ? RS_BLOCKED : RS_SLEEP;
                        wake_reg[idx_reg] <= item_reg.deadline;
                    end
                    else
                    begin
                        rs_reg[idx_reg]   <= RS_READY;
                        wake_reg[idx_reg] <= NEVER_MS;
                    end
                    val_reg[idx_reg] <= item_reg.value;
                    out_valid        <= 1'b1;
                    status           <= ST_DONE;
                    chosen_slot      <= '0;
                    chosen_id        <= '0;
                    chosen_value     <= '0;
                    switched         <= 1'b0;
                    state_reg        <= S_IDLE;
                end
                S_SAVE:
                begin
                    val_reg[idx_reg] <= item_reg.value;
                    if (rd_rs == RS_RUN)
                    begin
                        rs_reg[idx_reg] <= RS_READY;
                    end
                    idx_reg   <= '0;
                    bv_reg    <= 1'b0;
                    state_reg <= S_PICK;
                end
                S_PICK:
                begin
                    if (pick_hit)
                    begin
                        bv_reg <= 1'b1;
                        bi_reg <= idx_reg;
                        bp_reg <= rd_prio;
                    end
                    if (last)
                    begin
                        if (pick_hit || bv_reg)
                        begin
                            idx_reg   <= pick_hit ? idx_reg : bi_reg;
                            idle_reg  <= 1'b0;
                            fin_reg   <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else if (!jumped_reg)
                        begin
                            idx_reg   <= '0;
                            ear_reg   <= NEVER_MS;
                            state_reg <= S_EARLY;
                        end
                        else
                        begin
                            idx_reg   <= cur_reg;
                            idle_reg  <= 1'b1;
                            fin_reg   <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_EARLY:
                begin
                    if (early_hit)
                    begin
                        ear_reg <= rd_wake;
                    end
                    if (last)
                    begin
                        if (!early_hit && ear_reg == NEVER_MS)
                        begin
                            idx_reg   <= cur_reg;
                            idle_reg  <= 1'b1;
                            fin_reg   <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            if ((early_hit ? rd_wake : ear_reg) > clock_reg)
                            begin
                                clock_reg <= early_hit ? rd_wake : ear_reg;
                            end
                            idx_reg   <= '0;
                            state_reg <= S_WAKE;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_WAKE:
                begin
                    if (wake_hit)
                    begin
                        if (rd_rs == RS_BLOCKED)
                        begin
                            val_reg[idx_reg] <= TIMEOUT_VALUE;
                        end
                        rs_reg[idx_reg]   <= RS_READY;
                        wake_reg[idx_reg] <= NEVER_MS;
                    end
                    if (last)
                    begin
                        idx_reg    <= '0;
                        bv_reg     <= 1'b0;
                        jumped_reg <= 1'b1;
                        state_reg  <= S_PICK;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/priority_thread_scheduler_top.sv @@
`timescale 1ns / 1ps
// Priority thread scheduler: a table of THREAD_SLOTS thread slots with a virtual
// millisecond clock. Each input word (allocate, park, wake, schedule) gives one
// result word. Words enter a two-entry queue, so a new word is taken while the
// previous one still runs or waits at the output. Allocate runs a first-free
// scan; schedule picks a ready thread, or, when no thread is ready and the clock
// must jump, runs pick, earliest deadline, wake and pick again. Each scan reads
// one slot-table entry per cycle. A word leaves the queue only once the output
// register is empty.
module priority_thread_scheduler_top #(
    parameter int THREAD_SLOTS = psch_pkg::THREAD_SLOTS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [1:0]   func,
    input  logic [3:0]   slot,
    input  logic [7:0]   priority_req,
    input  logic         wait_blocked,
    input  logic [31:0]  deadline,
    input  logic [31:0]  value,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [1:0]   status,
    output logic [3:0]   chosen_slot,
    output logic [31:0]  chosen_id,
    output logic [31:0]  chosen_value,
    output logic         switched,
    output logic [31:0]  clock_now
);
    import psch_pkg::*;

    logic   q_valid;
    item_t  q_item;
    logic   q_pop;

    psch_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .slot         (slot),
        .priority_req (priority_req),
        .wait_blocked (wait_blocked),
        .deadline     (deadline),
        .value        (value),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop)
    );

    psch_core #(
        .THREAD_SLOTS (THREAD_SLOTS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .chosen_slot  (chosen_slot),
        .chosen_id    (chosen_id),
        .chosen_value (chosen_value),
        .switched     (switched),
        .clock_now    (clock_now)
    );

endmodule

@@ rtl/psch_checker.sv @@
`timescale 1ns / 1ps
module psch_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [1:0]   status,
    input  logic [3:0]   chosen_slot,
    input  logic [31:0]  chosen_id,
    input  logic [31:0]  chosen_value,
    input  logic         switched,
    input  logic [31:0]  clock_now
);
    import psch_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(chosen_id))
        else $error("result word dropped or changed while stalled");

    a_switch_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && switched |-> status == ST_DONE)
        else $error("switch reported with non-done status");

    a_no_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_NO_SLOT |->
            chosen_slot == 4'd0 && chosen_id == 32'd0 && chosen_value == 32'd0 && !switched)
        else $error("full-table result carries data");

    a_clock_fwd: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> clock_now >= $past(clock_now))
        else $error("virtual clock moved backward");

endmodule

bind priority_thread_scheduler_top psch_checker u_psch_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .chosen_slot  (chosen_slot),
    .chosen_id    (chosen_id),
    .chosen_value (chosen_value),
    .switched     (switched),
    .clock_now    (clock_now)
);
